// ----- hdl/sea_pkg.sv -----
`timescale 1ns / 1ps
package sea_pkg;

  localparam int CoordW    = 16;
  localparam int HopW      = 8;
  localparam int StiffW    = 16;
  localparam int SpringW   = 16;
  localparam int EnergyW   = 63;
  localparam int MulW      = 24;
  localparam int ProdW     = 2 * MulW;
  localparam int SqInW     = 34;
  localparam int RootW     = SqInW / 2;
  localparam int SqrtSteps = RootW;
  localparam int TermW     = 64;

  localparam logic [SpringW-1:0] SpringLenReset = SpringW'(800);
  localparam logic [EnergyW-1:0] EnergyMax      = {EnergyW{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MX,
    ST_MY,
    ST_MR,
    ST_SQS,
    ST_SQW,
    ST_MD,
    ST_ML,
    ST_MH,
    ST_SUM,
    ST_ACC
  } sea_state_e;

  typedef struct packed {
    logic [MulW-1:0] a;
    logic [MulW-1:0] b;
  } sea_mul_op_t;

endpackage

// ----- hdl/sea_mul.sv -----
`timescale 1ns / 1ps
module sea_mul import sea_pkg::*; (
  input  logic              clk_i,
  input  sea_mul_op_t       op_i,
  output logic [ProdW-1:0]  prod_o
);

  logic [ProdW-1:0] prod_q;

  // The product is registered so that nothing else follows it in the same cycle.
  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(op_i.a) * ProdW'(op_i.b);
  end

  assign prod_o = prod_q;

endmodule

// ----- hdl/sea_sqrt.sv -----
`timescale 1ns / 1ps
module sea_sqrt import sea_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SqInW-1:0]  radicand_i,
  output logic              done_o,
  output logic [RootW-1:0]  root_o
);

  localparam int CntW = $clog2(SqrtSteps + 1);
  localparam int RemW = RootW + 3;

  logic              busy_q;
  logic              done_q;
  logic [CntW-1:0]   cnt_q;
  logic [SqInW-1:0]  rad_q;
  logic [RemW-1:0]   rem_q;
  logic [RootW-1:0]  root_q;

  logic [RemW-1:0]   rem_nx;
  logic [RemW-1:0]   trial;
  logic              fits;

  // One result bit per step: bring down two radicand bits, try root*4+1.
  assign rem_nx = {rem_q[RemW-3:0], rad_q[SqInW-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign fits   = (rem_nx >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(SqrtSteps);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[SqInW-3:0], 2'b00};
      rem_q  <= fits ? (rem_nx - trial) : rem_nx;
      root_q <= {root_q[RootW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ----- hdl/spring_energy_accumulator.sv -----
`timescale 1ns / 1ps
// Spring energy accumulator: each input word is one graph edge, and the block adds
// stiffness * (length - hop_distance * rest_len)^2 to an unsigned saturating sum,
// emitting the sum and its saturation flag on the edge marked last and then clearing
// both. One edge occupies the block from acceptance until in_ready_o rises again, so
// a new edge is taken only when the last is through. The bit-serial square root
// yields one root bit per cycle for its 17 bits; six passes go through the single
// shared 24x24 multiplier, plus the final add and saturate step. A last edge waits
// in its final step while an earlier result word is still held on the output.
module spring_energy_accumulator import sea_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [SpringW-1:0]  cfg_rest_len_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [CoordW-1:0]   first_x_i,
  input  logic [CoordW-1:0]   first_y_i,
  input  logic [CoordW-1:0]   second_x_i,
  input  logic [CoordW-1:0]   second_y_i,
  input  logic [HopW-1:0]     hop_distance_i,
  input  logic [StiffW-1:0]   stiffness_i,
  input  logic                last_edge_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [EnergyW-1:0]  energy_o,
  output logic                saturated_o
);

  sea_state_e state_q, state_d;

  logic [SpringW-1:0]  spl_q;
  logic [EnergyW-1:0]  sum_q;
  logic                sat_q;
  logic                out_valid_q;
  logic [EnergyW-1:0]  out_energy_q;
  logic                out_sat_q;

  logic [CoordW-1:0]   adx_q, ady_q;
  logic [HopW-1:0]     hop_q;
  logic [StiffW-1:0]   k_q;
  logic                last_q;
  logic [SqInW-1:0]    sq_q;
  logic [MulW-1:0]     rest_q;
  logic [MulW-1:0]     d_q;
  logic [ProdW-1:0]    dd_q;
  logic [TermW-1:0]    term_q;

  logic [CoordW:0]     dx, dy;
  logic [CoordW-1:0]   adx, ady;
  logic                in_fire;
  sea_mul_op_t         mul_op;
  logic [ProdW-1:0]    prod;
  logic                sqrt_start;
  logic                sqrt_done;
  logic [RootW-1:0]    root;
  logic [MulW-1:0]     root_ext;

  logic [TermW:0]      exact;
  logic                hit;
  logic [EnergyW-1:0]  new_sum;
  logic                new_sat;
  logic                out_free;
  logic                acc_fire;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;

  assign dx  = {second_x_i[CoordW-1], second_x_i} - {first_x_i[CoordW-1], first_x_i};
  assign dy  = {second_y_i[CoordW-1], second_y_i} - {first_y_i[CoordW-1], first_y_i};
  assign adx = dx[CoordW] ? CoordW'(-dx) : dx[CoordW-1:0];
  assign ady = dy[CoordW] ? CoordW'(-dy) : dy[CoordW-1:0];

  assign root_ext = MulW'(root);

  // The exact sum is one bit wider than the term, so the saturation test cannot wrap.
  assign exact    = {2'b00, sum_q} + {1'b0, term_q};
  assign hit      = (exact >= {2'b00, EnergyMax});
  assign new_sum  = hit ? EnergyMax : exact[EnergyW-1:0];
  assign new_sat  = sat_q || hit;
  assign out_free = !out_valid_q || out_ready_i;
  assign acc_fire = (state_q == ST_ACC) && last_q && out_free;

  sea_mul u_mul (
    .clk_i  (clk_i),
    .op_i   (mul_op),
    .prod_o (prod)
  );

  sea_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (sq_q),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    mul_op.a   = MulW'(adx_q);
    mul_op.b   = MulW'(adx_q);
    sqrt_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_MX;
      end
      ST_MX: begin
        state_d = ST_MY;
      end
      ST_MY: begin
        mul_op.a = MulW'(ady_q);
        mul_op.b = MulW'(ady_q);
        state_d  = ST_MR;
      end
      ST_MR: begin
        mul_op.a = MulW'(hop_q);
        mul_op.b = MulW'(spl_q);
        state_d  = ST_SQS;
      end
      ST_SQS: begin
        sqrt_start = 1'b1;
        state_d    = ST_SQW;
      end
      ST_SQW: begin
        if (sqrt_done) state_d = ST_MD;
      end
      ST_MD: begin
        mul_op.a = d_q;
        mul_op.b = d_q;
        state_d  = ST_ML;
      end
      ST_ML: begin
        // The low half of d^2 goes straight from the product register.
        mul_op.a = prod[MulW-1:0];
        mul_op.b = MulW'(k_q);
        state_d  = ST_MH;
      end
      ST_MH: begin
        mul_op.a = dd_q[ProdW-1:MulW];
        mul_op.b = MulW'(k_q);
        state_d  = ST_SUM;
      end
      ST_SUM: begin
        state_d = ST_ACC;
      end
      ST_ACC: begin
        if (!last_q || out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      adx_q  <= adx;
      ady_q  <= ady;
      hop_q  <= hop_distance_i;
      k_q    <= stiffness_i;
      last_q <= last_edge_i;
    end
    case (state_q)
      ST_MY:  sq_q   <= prod[SqInW-1:0];
      ST_MR:  sq_q   <= sq_q + prod[SqInW-1:0];
      ST_SQS: rest_q <= prod[MulW-1:0];
      ST_SQW: begin
        if (sqrt_done) d_q <= (root_ext >= rest_q) ? (root_ext - rest_q) : (rest_q - root_ext);
      end
      ST_ML:  dd_q   <= prod;
      ST_MH:  term_q <= TermW'(prod[StiffW+MulW-1:0]);
      ST_SUM: term_q <= term_q + {prod[StiffW+MulW-1:0], {MulW{1'b0}}};
      default: begin
      end
    endcase
    if (acc_fire) begin
      out_energy_q <= new_sum;
      out_sat_q    <= new_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spl_q       <= SpringLenReset;
      sum_q       <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) spl_q <= cfg_rest_len_i;
      if (state_q == ST_ACC) begin
        if (!last_q) begin
          sum_q <= new_sum;
          sat_q <= new_sat;
        end else if (out_free) begin
          sum_q <= '0;
          sat_q <= 1'b0;
        end
      end
      if (acc_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign energy_o    = out_energy_q;
  assign saturated_o = out_sat_q;

  // A set flag always comes with a clamped sum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sat_q |-> (sum_q == EnergyMax))
    else $error("saturation flag set while the sum is below its maximum");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_sat_q) |-> (out_energy_q == EnergyMax))
    else $error("result word flagged saturated without a clamped energy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_done |-> (state_q == ST_SQW))
    else $error("square root finished outside its wait step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_ACC && last_q))
    else $error("result word raised without a last edge");

endmodule
